/* sv/cfwp_pkg.sv */
// ----------------------------------------------------------------------------
// cfwp_pkg: shared types and constants of the circular fifo with peek
// command and status codes, index widths and wrap helpers
// ----------------------------------------------------------------------------
package cfwp_pkg;

    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int OUT_W      = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH       = 3'd0,
        CMD_POP        = 3'd1,
        CMD_FRONT      = 3'd2,
        CMD_BACK       = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_DUMP_FWD   = 3'd6,
        CMD_DUMP_REV   = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } state_t;

    // modular add of two indices, both below depth
    function automatic idx_t idx_add(input idx_t a, input idx_t b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t idx_inc(input idx_t a);
        return idx_add(a, IDX_W'(1));
    endfunction

    function automatic idx_t idx_dec(input idx_t a);
        return idx_add(a, IDX_W'(DEPTH - 1));
    endfunction

endpackage

/* sv/cfwp_ram.sv */
// ----------------------------------------------------------------------------
// cfwp_ram: simple dual-port ram
// one write port, one read port with registered read data held between reads
// ----------------------------------------------------------------------------
module cfwp_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 8,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/circular_fifo_with_peek.sv */
// ----------------------------------------------------------------------------
// circular_fifo_with_peek: circular fifo of signed words with peek and dump
// order: accepted in S_IDLE, the result is registered in S_RESULT once out_free
// throughput: one item at a time, a new one only in S_IDLE; a dump streams one entry
//   per cycle after the first while m_ready holds, set by the single ram read port
// reset: head, tail and count clear at once, no clearing pass; storage is not reset
// ----------------------------------------------------------------------------
module circular_fifo_with_peek (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // item input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [cfwp_pkg::CMD_W-1:0]           s_command,
    input  logic signed [31:0]                   s_value,
    input  logic [cfwp_pkg::POS_W-1:0]           s_position,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [cfwp_pkg::STATUS_W-1:0]        m_status,
    output logic signed [cfwp_pkg::OUT_W-1:0]    m_data,
    output logic                                 m_last,
    output logic [cfwp_pkg::CNT_W-1:0]           m_count,
    output logic                                 m_is_empty,
    output logic                                 m_is_full
);

    // control state
    cfwp_pkg::state_t  state_reg,  state_next;
    cfwp_pkg::idx_t    head_reg,   head_next;
    cfwp_pkg::idx_t    tail_reg,   tail_next;
    cfwp_pkg::cnt_t    occ_reg,    occ_next;
    logic              m_valid_reg, m_valid_next;

    // latched item context
    cfwp_pkg::cmd_t    cmd_reg,    cmd_next;
    cfwp_pkg::status_t status_reg, status_next;
    cfwp_pkg::idx_t    ptr_reg,    ptr_next;   // dump read pointer
    cfwp_pkg::cnt_t    rem_reg,    rem_next;   // dump entries left after current

    // output payload
    cfwp_pkg::status_t out_status_reg, out_status_next;
    logic [cfwp_pkg::OUT_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg,   out_last_next;
    cfwp_pkg::cnt_t    out_count_reg,  out_count_next;

    // ram port
    logic                              wr_en;
    cfwp_pkg::idx_t                    wr_addr;
    logic [cfwp_pkg::DATA_WIDTH-1:0]   wr_data;
    logic                              rd_en;
    cfwp_pkg::idx_t                    rd_addr;
    logic [cfwp_pkg::DATA_WIDTH-1:0]   rd_data;

    cfwp_pkg::cmd_t    s_cmd;
    logic              peek_bad;
    cfwp_pkg::idx_t    front_off;
    cfwp_pkg::idx_t    back_off;
    logic              is_dump;
    logic              out_free;
    logic              final_result;
    cfwp_pkg::idx_t    dump_step;

    // word storage, one read and one write per cycle; a push to an empty fifo reads and
    // writes the same entry in one cycle, but its read data is never used
    cfwp_ram #(
        .WIDTH (cfwp_pkg::DATA_WIDTH),
        .WORDS (cfwp_pkg::DEPTH),
        .AW    (cfwp_pkg::IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_cmd = cfwp_pkg::cmd_t'(s_command);

    // peek position check and offsets from either end
    assign peek_bad  = (s_position == '0) || (int'(s_position) > int'(occ_reg));
    assign front_off = cfwp_pkg::IDX_W'(int'(s_position) - 1);
    assign back_off  = cfwp_pkg::IDX_W'(cfwp_pkg::DEPTH - int'(s_position));

    assign is_dump      = (cmd_reg == cfwp_pkg::CMD_DUMP_FWD) ||
                          (cmd_reg == cfwp_pkg::CMD_DUMP_REV);
    assign out_free     = !m_valid_reg || m_ready;
    // a dump with entries ends when no entries remain; everything else is one result
    assign final_result = !(is_dump && (status_reg == cfwp_pkg::STAT_OK)) ||
                          (rem_reg == '0);
    assign dump_step    = (cmd_reg == cfwp_pkg::CMD_DUMP_FWD) ?
                          cfwp_pkg::idx_inc(ptr_reg) : cfwp_pkg::idx_dec(ptr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cfwp_pkg::S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item context and payload need no reset
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        status_reg     <= status_next;
        ptr_reg        <= ptr_next;
        rem_reg        <= rem_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        cmd_next        = cmd_reg;
        status_next     = status_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        s_ready         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_data         = cfwp_pkg::DATA_WIDTH'(s_value);
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        unique case (state_reg)
            cfwp_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // accept: decide status, update pointers, issue the first read
                    cmd_next    = s_cmd;
                    status_next = cfwp_pkg::STAT_OK;
                    rd_en       = 1'b1;
                    unique case (s_cmd)
                        cfwp_pkg::CMD_PUSH: begin
                            if (occ_reg == cfwp_pkg::CNT_W'(cfwp_pkg::DEPTH)) begin
                                status_next = cfwp_pkg::STAT_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                tail_next = cfwp_pkg::idx_inc(tail_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        cfwp_pkg::CMD_POP: begin
                            if (occ_reg == '0) begin
                                status_next = cfwp_pkg::STAT_EMPTY;
                            end else begin
                                head_next = cfwp_pkg::idx_inc(head_reg);
                                occ_next  = occ_reg - 1'b1;
                            end
                        end
                        cfwp_pkg::CMD_FRONT, cfwp_pkg::CMD_DUMP_FWD: begin
                            rd_addr = head_reg;
                            if (occ_reg == '0) begin
                                status_next = cfwp_pkg::STAT_EMPTY;
                            end
                        end
                        cfwp_pkg::CMD_BACK, cfwp_pkg::CMD_DUMP_REV: begin
                            rd_addr = cfwp_pkg::idx_dec(tail_reg);
                            if (occ_reg == '0) begin
                                status_next = cfwp_pkg::STAT_EMPTY;
                            end
                        end
                        cfwp_pkg::CMD_PEEK_FRONT: begin
                            rd_addr = cfwp_pkg::idx_add(head_reg, front_off);
                            if (occ_reg == '0) begin
                                status_next = cfwp_pkg::STAT_EMPTY;
                            end else if (peek_bad) begin
                                status_next = cfwp_pkg::STAT_RANGE;
                            end
                        end
                        cfwp_pkg::CMD_PEEK_BACK: begin
                            rd_addr = cfwp_pkg::idx_add(tail_reg, back_off);
                            if (occ_reg == '0) begin
                                status_next = cfwp_pkg::STAT_EMPTY;
                            end else if (peek_bad) begin
                                status_next = cfwp_pkg::STAT_RANGE;
                            end
                        end
                        default: begin
                            status_next = cfwp_pkg::STAT_EMPTY;
                        end
                    endcase
                    ptr_next   = rd_addr;
                    rem_next   = occ_reg - 1'b1;
                    state_next = cfwp_pkg::S_RESULT;
                end
            end
            cfwp_pkg::S_RESULT: begin
                // read data is valid here and holds while the output stalls
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_last_next   = final_result;
                    out_count_next  = occ_reg;
                    if ((status_reg == cfwp_pkg::STAT_OK) &&
                        (cmd_reg != cfwp_pkg::CMD_PUSH) &&
                        (cmd_reg != cfwp_pkg::CMD_POP)) begin
                        out_data_next = cfwp_pkg::OUT_W'(rd_data);
                    end else begin
                        out_data_next = '0;
                    end
                    if (final_result) begin
                        state_next = cfwp_pkg::S_IDLE;
                    end else begin
                        // next dump entry
                        rd_en    = 1'b1;
                        rd_addr  = dump_step;
                        ptr_next = dump_step;
                        rem_next = rem_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = cfwp_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = out_status_reg;
    assign m_data     = out_data_reg;
    assign m_last     = out_last_reg;
    assign m_count    = out_count_reg;
    assign m_is_empty = (out_count_reg == '0);
    assign m_is_full  = (out_count_reg == cfwp_pkg::CNT_W'(cfwp_pkg::DEPTH));

endmodule
